[src/avu_pkg.sv]
// Shared constants, types and state encodings for the angle unwrap / velocity unit.
// Used by avu_tracker, avu_velocity and angle_unwrap_velocity_estimator_unit.
package avu_pkg;

    localparam int FRAC_BITS = 16;

    localparam int ANGLE_W   = 19;
    localparam int TIME_W    = 32;
    localparam int TURN_W    = 32;
    localparam int CFG_W     = 16;
    localparam int UNW_W     = 48;
    localparam int VEL_W     = 32;
    localparam int BASE_W    = 51;
    localparam int CUR_W     = BASE_W + 1;
    localparam int DELTA_W   = CUR_W + 1;
    localparam int MAG_W     = CUR_W;
    localparam int SCALE_W   = 20;
    localparam int PROD_W    = MAG_W + SCALE_W;
    localparam int CNT_W     = $clog2(TIME_W);
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 112;
    localparam int M_USER_W  = 2;

    localparam logic [63:0] TWO_PI_Q32  = 64'd26986075409;
    localparam logic [63:0] WRAP_Q32    = 64'd21588860327;
    localparam logic [63:0] TWO_PI_FULL =
        (TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

    localparam logic [ANGLE_W-1:0] TWO_PI     = ANGLE_W'(TWO_PI_FULL);
    localparam logic [ANGLE_W-1:0] WRAP_LIMIT = ANGLE_W'(WRAP_Q32 >> (32 - FRAC_BITS));

    // base (turns * 2pi) at the two ends of the signed turn range
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(TWO_PI_FULL * 64'h7FFF_FFFF);
    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(64'd0 - TWO_PI_FULL * 64'h8000_0000);

    localparam logic [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

    localparam logic [SCALE_W-1:0] MICRO_SCALE = SCALE_W'(1000000);
    localparam logic [CFG_W-1:0]   CFG_RESET   = CFG_W'(100);

    localparam logic [VEL_W-1:0] VEL_POS_LIMIT = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_NEG_LIMIT = {1'b1, {(VEL_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNWRAP,
        ST_SUM,
        ST_DELTA,
        ST_DECIDE,
        ST_DIV,
        ST_EMIT
    } avu_state_t;

    typedef enum logic [2:0] {
        VU_IDLE,
        VU_MUL,
        VU_CHK,
        VU_DIV,
        VU_FIN
    } vu_state_t;

    typedef struct packed {
        logic load;
        logic unwrap;
        logic sum;
        logic delta;
        logic decide;
    } trk_ctrl_t;

    typedef struct packed {
        logic fault;
        logic refresh;
    } trk_stat_t;

endpackage

[src/angle_unwrap_velocity_estimator_unit.sv]
// Rotor angle unwrap and velocity estimate (avu_pkg, avu_tracker, avu_velocity). A faulted
// beat goes from unwrap straight to the output step; otherwise sum, delta and decide follow,
// and on a velocity update a serial x1e6 and a restoring divide, the divide being skipped
// when the quotient overflows and saturates. Next beat is taken the cycle after the result
// enters the output register, so no new beat is taken while one is in progress or waits on m_tready.
// Synchronous active-low reset clears all tracking state; min_elapsed_us resets to 100.
module angle_unwrap_velocity_estimator_unit import avu_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,     // min_elapsed_us
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,         // sample_angle[18:0], timestamp_us[50:19]
    input  logic                s_tuser,         // sample_fault
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,         // rotation_count[31:0],
                                                 // unwrapped_angle[79:32],
                                                 // angular_velocity[111:80]
    output logic [M_USER_W-1:0] m_tuser          // velocity_refreshed[0], sample_rejected[1]
);

    avu_state_t          state_reg, state_next;
    logic [CFG_W-1:0]    min_elapsed_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_USER_W-1:0] m_tuser_reg;

    trk_ctrl_t           trk_ctrl;
    trk_stat_t           trk_stat;
    logic [TURN_W-1:0]   trk_turn;
    logic [UNW_W-1:0]    trk_unw;
    logic [VEL_W-1:0]    trk_vel;
    logic [MAG_W-1:0]    trk_mag;
    logic                trk_neg;
    logic [TIME_W-1:0]   trk_elapsed;
    logic                trk_refreshed;
    logic                vu_start;
    logic                vu_done;
    logic [VEL_W-1:0]    vu_velocity;
    logic                out_load;
    logic                out_free;

    avu_tracker u_tracker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (trk_ctrl),
        .in_angle        (s_tdata[ANGLE_W-1:0]),
        .in_fault        (s_tuser),
        .in_time         (s_tdata[ANGLE_W+TIME_W-1:ANGLE_W]),
        .min_elapsed     (min_elapsed_reg),
        .vel_done        (vu_done),
        .vel_value       (vu_velocity),
        .stat            (trk_stat),
        .turn_count      (trk_turn),
        .unwrapped_angle (trk_unw),
        .held_velocity   (trk_vel),
        .delta_mag       (trk_mag),
        .delta_neg       (trk_neg),
        .elapsed         (trk_elapsed),
        .refreshed       (trk_refreshed)
    );

    avu_velocity u_velocity (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (vu_start),
        .mag      (trk_mag),
        .neg      (trk_neg),
        .den      (trk_elapsed),
        .done     (vu_done),
        .velocity (vu_velocity)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        trk_ctrl        = '0;
        vu_start        = 1'b0;
        out_load        = 1'b0;
        s_tready        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                trk_ctrl.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_UNWRAP;
                end
            end
            ST_UNWRAP: begin
                trk_ctrl.unwrap = 1'b1;
                state_next      = trk_stat.fault ? ST_EMIT : ST_SUM;
            end
            ST_SUM: begin
                trk_ctrl.sum = 1'b1;
                state_next   = ST_DELTA;
            end
            ST_DELTA: begin
                trk_ctrl.delta = 1'b1;
                state_next     = ST_DECIDE;
            end
            ST_DECIDE: begin
                trk_ctrl.decide = 1'b1;
                vu_start        = trk_stat.refresh;
                state_next      = trk_stat.refresh ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (vu_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            min_elapsed_reg <= CFG_RESET;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                min_elapsed_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {trk_vel, trk_unw, trk_turn};
            m_tuser_reg <= {trk_stat.fault, trk_refreshed};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("refreshed and rejected both set");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        vu_done |-> (state_reg == ST_DIV))
        else $error("velocity unit finished outside divide phase");

    a_turn_only_on_unwrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_UNWRAP) |=> $stable(trk_turn))
        else $error("turn count changed outside unwrap step");

endmodule

[src/avu_tracker.sv]
// Angle unwrap and reference tracking: turn count, unwrapped angle, delta and elapsed time.
// Depends on avu_pkg; stepped by the top-level sequencer through trk_ctrl_t.
module avu_tracker import avu_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  trk_ctrl_t          ctrl,
    input  logic [ANGLE_W-1:0] in_angle,
    input  logic               in_fault,
    input  logic [TIME_W-1:0]  in_time,
    input  logic [CFG_W-1:0]   min_elapsed,
    input  logic               vel_done,
    input  logic [VEL_W-1:0]   vel_value,
    output trk_stat_t          stat,
    output logic [TURN_W-1:0]  turn_count,
    output logic [UNW_W-1:0]   unwrapped_angle,
    output logic [VEL_W-1:0]   held_velocity,
    output logic [MAG_W-1:0]   delta_mag,
    output logic               delta_neg,
    output logic [TIME_W-1:0]  elapsed,
    output logic               refreshed
);

    logic [ANGLE_W-1:0] angle_in_reg;
    logic [TIME_W-1:0]  time_in_reg;
    logic               fault_reg;
    logic [ANGLE_W-1:0] last_angle_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [TURN_W-1:0]  turn_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [CUR_W-1:0]   cur_reg;
    logic [CUR_W-1:0]   ref_unw_reg;
    logic [TIME_W-1:0]  ref_time_reg;
    logic [VEL_W-1:0]   held_vel_reg;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic               time_ok_reg;
    logic               refreshed_reg;

    logic               angle_up;
    logic [ANGLE_W-1:0] jump;
    logic               is_wrap;
    logic [TURN_W-1:0]  turn_next;
    logic [BASE_W-1:0]  base_next;
    logic [BASE_W-1:0]  two_pi_ext;
    logic [CUR_W-1:0]   cur_next;
    logic [DELTA_W-1:0] delta_next;
    logic [DELTA_W-1:0] delta_abs;
    logic               refresh;

    assign two_pi_ext = {{(BASE_W-ANGLE_W){1'b0}}, TWO_PI};
    assign angle_up   = angle_in_reg > last_angle_reg;
    assign jump       = angle_up ? (angle_in_reg - last_angle_reg)
                                 : (last_angle_reg - angle_in_reg);
    assign is_wrap    = jump > WRAP_LIMIT;

    always_comb begin
        turn_next = turn_reg;
        base_next = base_reg;
        if (is_wrap) begin
            if (angle_up) begin
                turn_next = turn_reg - TURN_W'(1);
                base_next = (turn_reg == TURN_MIN) ? BASE_MAX : (base_reg - two_pi_ext);
            end else begin
                turn_next = turn_reg + TURN_W'(1);
                base_next = (turn_reg == TURN_MAX) ? BASE_MIN : (base_reg + two_pi_ext);
            end
        end
    end

    assign cur_next   = {base_reg[BASE_W-1], base_reg}
                      + {{(CUR_W-ANGLE_W){1'b0}}, last_angle_reg};
    assign delta_next = {cur_reg[CUR_W-1], cur_reg} - {ref_unw_reg[CUR_W-1], ref_unw_reg};
    assign delta_neg  = delta_reg[DELTA_W-1];
    assign delta_abs  = delta_neg ? (DELTA_W'(0) - delta_reg) : delta_reg;
    assign delta_mag  = delta_abs[MAG_W-1:0];
    assign refresh    = time_ok_reg && (delta_reg != '0);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            angle_in_reg <= in_angle;
            time_in_reg  <= in_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg      <= 1'b0;
            last_angle_reg <= '0;
            last_time_reg  <= '0;
            turn_reg       <= '0;
            base_reg       <= '0;
            cur_reg        <= '0;
            ref_unw_reg    <= '0;
            ref_time_reg   <= '0;
            held_vel_reg   <= '0;
            elapsed_reg    <= '0;
            delta_reg      <= '0;
            time_ok_reg    <= 1'b0;
            refreshed_reg  <= 1'b0;
        end else begin
            if (ctrl.load) begin
                fault_reg <= in_fault;
            end
            if (ctrl.unwrap) begin
                refreshed_reg <= 1'b0;
                if (!fault_reg) begin
                    turn_reg       <= turn_next;
                    base_reg       <= base_next;
                    last_angle_reg <= angle_in_reg;
                    last_time_reg  <= time_in_reg;
                end
            end
            if (ctrl.sum) begin
                cur_reg     <= cur_next;
                elapsed_reg <= last_time_reg - ref_time_reg;
            end
            if (ctrl.delta) begin
                delta_reg   <= delta_next;
                time_ok_reg <= elapsed_reg >= TIME_W'(min_elapsed);
            end
            if (ctrl.decide && refresh) begin
                ref_unw_reg   <= cur_reg;
                ref_time_reg  <= last_time_reg;
                refreshed_reg <= 1'b1;
            end
            if (vel_done) begin
                held_vel_reg <= vel_value;
            end
        end
    end

    assign stat.fault      = fault_reg;
    assign stat.refresh    = refresh;
    assign turn_count      = turn_reg;
    assign unwrapped_angle = cur_reg[UNW_W-1:0];
    assign held_velocity   = held_vel_reg;
    assign elapsed         = elapsed_reg;
    assign refreshed       = refreshed_reg;

endmodule

[src/avu_velocity.sv]
// Bit-serial velocity unit: |delta| * 1e6 by shift-add, then restoring divide by elapsed us.
// Saturates to the signed 32-bit range and applies the sign. Depends on avu_pkg.
module avu_velocity import avu_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MAG_W-1:0]  mag,
    input  logic              neg,
    input  logic [TIME_W-1:0] den,
    output logic              done,
    output logic [VEL_W-1:0]  velocity
);

    vu_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               neg_reg;
    logic [TIME_W-1:0]  den_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [TIME_W-1:0]  rem_reg;
    logic [TIME_W-1:0]  quo_reg;

    logic [PROD_W-1:0]        acc_next;
    logic [PROD_W-TIME_W-1:0] acc_hi;
    logic                     ovf;
    logic [TIME_W:0]          trial;
    logic                     ge;
    logic [TIME_W:0]          diff;
    logic [VEL_W-1:0]         limit;
    logic [VEL_W-1:0]         sat;

    assign acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                    + (MICRO_SCALE[cnt_reg] ? PROD_W'(mag_reg) : PROD_W'(0));
    assign acc_hi   = acc_reg[PROD_W-1:TIME_W];
    assign ovf      = acc_hi >= (PROD_W-TIME_W)'(den_reg);
    assign trial    = {rem_reg, quo_reg[TIME_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= VU_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        done       = 1'b0;
        unique case (state_reg)
            VU_IDLE: begin
                if (start) begin
                    state_next = VU_MUL;
                end
            end
            VU_MUL: begin
                if (cnt_reg == '0) begin
                    state_next = VU_CHK;
                end
            end
            VU_CHK: begin
                state_next = ovf ? VU_FIN : VU_DIV;
            end
            VU_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = VU_FIN;
                end
            end
            VU_FIN: begin
                done       = 1'b1;
                state_next = VU_IDLE;
            end
            default: begin
                state_next = VU_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            VU_IDLE: begin
                if (start) begin
                    mag_reg <= mag;
                    neg_reg <= neg;
                    den_reg <= den;
                    acc_reg <= '0;
                    cnt_reg <= CNT_W'(SCALE_W - 1);
                end
            end
            VU_MUL: begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            VU_CHK: begin
                rem_reg <= acc_hi[TIME_W-1:0];
                quo_reg <= ovf ? '1 : acc_reg[TIME_W-1:0];
                cnt_reg <= CNT_W'(TIME_W - 1);
            end
            VU_DIV: begin
                rem_reg <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
                quo_reg <= {quo_reg[TIME_W-2:0], ge};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign limit    = neg_reg ? VEL_NEG_LIMIT : VEL_POS_LIMIT;
    assign sat      = (quo_reg > limit) ? limit : quo_reg;
    assign velocity = neg_reg ? (VEL_W'(0) - sat) : sat;

endmodule
